### rtl/core/ppu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_pkg
// types, result codes and arithmetic helpers of the projectile pool
// ----------------------------------------------------------------------------
package ppu_pkg;

   localparam logic ACT_CREATE = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   localparam logic [1:0] KIND_CREATED = 2'd0;
   localparam logic [1:0] KIND_FULL    = 2'd1;
   localparam logic [1:0] KIND_REPORT  = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   typedef struct packed {
      logic               action;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] speed_x;
      logic signed [31:0] speed_y;
      logic signed [31:0] speed_z;
      logic [15:0]        owner;
      logic [30:0]        life_span;
      logic [15:0]        tick_time;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [5:0]         slot;
      logic signed [31:0] now_x;
      logic signed [31:0] now_y;
      logic signed [31:0] now_z;
      logic signed [31:0] prev_x;
      logic signed [31:0] prev_y;
      logic signed [31:0] prev_z;
      logic [15:0]        shooter;
      logic               final_flag;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] prev_x;
      logic signed [31:0] prev_y;
      logic signed [31:0] prev_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [15:0]        owner;
      logic [30:0]        life;
   } entry_type;

   typedef struct packed {
      logic       load_item;
      logic       rd_en;
      logic       mul_en;
      logic       wr_create;
      logic       wr_tick;
      logic       out_load;
      logic [1:0] out_kind;
      logic       out_final;
   } cmd_type;

   typedef struct packed {
      logic live_here;
      logic any_live;
      logic any_after;
      logic out_busy;
   } sts_type;

   function automatic logic signed [32:0] step_of(input logic signed [31:0] vel,
                                                  input logic [15:0] t);
      logic signed [48:0] prod;
      prod = vel * $signed({1'b0, t});
      return prod[48:16];
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] pos,
                                                  input logic signed [32:0] dlt);
      logic signed [33:0] sum;
      sum = {{2{pos[31]}}, pos} + {dlt[32], dlt};
      if (sum > 34'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (sum < -34'sd2147483648) begin
         return 32'sh80000000;
      end
      return sum[31:0];
   endfunction

endpackage
`default_nettype wire

### rtl/core/ppu_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_datapath
// slot memory, live bits, movement arithmetic and the result register
// ----------------------------------------------------------------------------
module ppu_datapath #(
   parameter int POOL_SIZE = 64,
   parameter int IDX_W     = 6
) (
   input  wire                 clock,
   input  wire                 reset,
   input  ppu_pkg::req_type    req_payload,
   input  ppu_pkg::cmd_type    cmd,
   input  wire [IDX_W-1:0]     idx,
   output ppu_pkg::sts_type    sts,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output ppu_pkg::rsp_type    rsp_payload
);
   import ppu_pkg::*;

   entry_type              pool_mem [POOL_SIZE];
   entry_type              rd_ff;
   entry_type              wr_entry;
   req_type                item_ff;
   logic [POOL_SIZE-1:0]   live_ff;
   logic [POOL_SIZE-1:0]   live_in;
   logic [POOL_SIZE-1:0]   live_up;
   logic signed [32:0]     dx_ff, dy_ff, dz_ff;
   logic [30:0]            life_new;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
      if (cmd.rd_en) begin
         rd_ff <= pool_mem[idx];
      end
      if (cmd.wr_create || cmd.wr_tick) begin
         pool_mem[idx] <= wr_entry;
      end
      if (cmd.mul_en) begin
         dx_ff <= step_of(rd_ff.vel_x, item_ff.tick_time);
         dy_ff <= step_of(rd_ff.vel_y, item_ff.tick_time);
         dz_ff <= step_of(rd_ff.vel_z, item_ff.tick_time);
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      life_new = (rd_ff.life > {15'd0, item_ff.tick_time})
               ? rd_ff.life - {15'd0, item_ff.tick_time} : 31'd0;
      wr_entry = rd_ff;
      if (cmd.wr_create) begin
         wr_entry.pos_x  = item_ff.start_x;
         wr_entry.pos_y  = item_ff.start_y;
         wr_entry.pos_z  = item_ff.start_z;
         wr_entry.prev_x = item_ff.start_x;
         wr_entry.prev_y = item_ff.start_y;
         wr_entry.prev_z = item_ff.start_z;
         wr_entry.vel_x  = item_ff.speed_x;
         wr_entry.vel_y  = item_ff.speed_y;
         wr_entry.vel_z  = item_ff.speed_z;
         wr_entry.owner  = item_ff.owner;
         wr_entry.life   = item_ff.life_span;
      end else begin
         wr_entry.prev_x = rd_ff.pos_x;
         wr_entry.prev_y = rd_ff.pos_y;
         wr_entry.prev_z = rd_ff.pos_z;
         wr_entry.pos_x  = sat_add(rd_ff.pos_x, dx_ff);
         wr_entry.pos_y  = sat_add(rd_ff.pos_y, dy_ff);
         wr_entry.pos_z  = sat_add(rd_ff.pos_z, dz_ff);
         wr_entry.life   = life_new;
      end
   end

   always_comb begin
      live_in = live_ff;
      if (cmd.wr_create || cmd.wr_tick) begin
         live_in[idx] = (wr_entry.life != 31'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   assign live_up       = (live_ff >> idx) >> 1;
   assign sts.live_here = live_ff[idx];
   assign sts.any_live  = |live_ff;
   assign sts.any_after = |live_up;
   assign sts.out_busy  = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_in             = '0;
      rsp_in.result_kind = cmd.out_kind;
      rsp_in.final_flag  = cmd.out_final;
      unique case (cmd.out_kind)
         KIND_CREATED: begin
            rsp_in.slot    = 6'(idx);
            rsp_in.now_x   = item_ff.start_x;
            rsp_in.now_y   = item_ff.start_y;
            rsp_in.now_z   = item_ff.start_z;
            rsp_in.prev_x  = item_ff.start_x;
            rsp_in.prev_y  = item_ff.start_y;
            rsp_in.prev_z  = item_ff.start_z;
            rsp_in.shooter = item_ff.owner;
         end
         KIND_REPORT: begin
            rsp_in.slot    = 6'(idx);
            rsp_in.now_x   = rd_ff.pos_x;
            rsp_in.now_y   = rd_ff.pos_y;
            rsp_in.now_z   = rd_ff.pos_z;
            rsp_in.prev_x  = rd_ff.prev_x;
            rsp_in.prev_y  = rd_ff.prev_y;
            rsp_in.prev_z  = rd_ff.prev_z;
            rsp_in.shooter = rd_ff.owner;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_create && cmd.wr_tick))
      else $error("create and tick write at once");
   a_tick_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_tick |-> $past(cmd.mul_en))
      else $error("tick write without product");
`endif

endmodule
`default_nettype wire

### rtl/core/ppu_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_control
// sequencer: create scan, tick update pass and live report pass
// ----------------------------------------------------------------------------
module ppu_control #(
   parameter int POOL_SIZE = 64,
   parameter int IDX_W     = 6
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_action,
   input  ppu_pkg::sts_type    sts,
   output ppu_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]    idx
);
   import ppu_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CSCAN  = 9'b000000010,
      S_CPUT   = 9'b000000100,
      S_TREAD  = 9'b000001000,
      S_TCALC  = 9'b000010000,
      S_TWRITE = 9'b000100000,
      S_RSCAN  = 9'b001000000,
      S_RPUT   = 9'b010000000,
      S_RNONE  = 9'b100000000
   } state_type;

   localparam logic [IDX_W-1:0] LAST = IDX_W'(POOL_SIZE - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic             found_ff, found_in;
   logic             accept;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign idx       = idx_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      start_in = start_ff;
      found_in = found_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               if (req_action == ACT_CREATE) begin
                  idx_in   = start_ff;
                  state_in = S_CSCAN;
               end else begin
                  idx_in   = '0;
                  state_in = S_TREAD;
               end
            end
         end
         S_CSCAN: begin
            if (!sts.live_here) begin
               cmd.wr_create = 1'b1;
               start_in      = idx_ff;
               found_in      = 1'b1;
               state_in      = S_CPUT;
            end else if (idx_ff == LAST) begin
               start_in = '0;
               found_in = 1'b0;
               state_in = S_CPUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CPUT: begin
            if (!sts.out_busy) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = found_ff ? KIND_CREATED : KIND_FULL;
               cmd.out_final = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_TREAD: begin
            if (sts.live_here) begin
               cmd.rd_en = 1'b1;
               state_in  = S_TCALC;
            end else if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = S_RSCAN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TCALC: begin
            cmd.mul_en = 1'b1;
            state_in   = S_TWRITE;
         end
         S_TWRITE: begin
            cmd.wr_tick = 1'b1;
            if (idx_ff == LAST) begin
               idx_in   = '0;
               state_in = S_RSCAN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_TREAD;
            end
         end
         S_RSCAN: begin
            if (!sts.any_live) begin
               state_in = S_RNONE;
            end else if (sts.live_here) begin
               cmd.rd_en = 1'b1;
               state_in  = S_RPUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RPUT: begin
            if (!sts.out_busy) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_REPORT;
               cmd.out_final = !sts.any_after;
               if (sts.any_after) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RSCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RNONE: begin
            if (!sts.out_busy) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_NONE;
               cmd.out_final = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         start_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         start_ff <= start_in;
         found_ff <= found_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted beat left sequencer idle");
   a_tick_write_order: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_tick |-> $past(state_ff == S_TCALC))
      else $error("tick write out of order");
   a_report_live: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_kind == KIND_REPORT) |-> sts.live_here)
      else $error("report of a free slot");
`endif

endmodule
`default_nettype wire

### rtl/core/projectile_pool_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// projectile_pool_update
// pool of projectiles: create into the first free slot at or after the start slot, tick and report
// ----------------------------------------------------------------------------
//  channel   direction  payload    handshake
//  req_      in         req_type   req_valid / req_stall
//  rsp_      out        rsp_type   rsp_valid / rsp_stall
//
//  create: scans slots upward from the start slot, then posts the result
//  tick: reads, multiplies and writes back each live slot and skips free
//  slots, then a report pass over the live slots up to the last live one,
//  or a single none result when none is live
//  one item at a time; reset clears the live bits and start slot
//  a result that finds the result register still stalled waits in place
// ----------------------------------------------------------------------------
module projectile_pool_update #(
   parameter int POOL_SIZE = 64
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  ppu_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output ppu_pkg::rsp_type  rsp_payload
);
   import ppu_pkg::*;

   localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

   cmd_type          cmd;
   sts_type          sts;
   logic [IDX_W-1:0] idx;

   ppu_control #(
      .POOL_SIZE (POOL_SIZE),
      .IDX_W     (IDX_W)
   ) u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_payload.action),
      .sts        (sts),
      .cmd        (cmd),
      .idx        (idx)
   );

   ppu_datapath #(
      .POOL_SIZE (POOL_SIZE),
      .IDX_W     (IDX_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .idx         (idx),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
